// File: rtl/core/hough_line_accumulator_top_defines.svh
// assertion macros for the hough line accumulator
`ifndef HOUGH_LINE_ACCUMULATOR_TOP_DEFINES_SVH
`define HOUGH_LINE_ACCUMULATOR_TOP_DEFINES_SVH

// same-cycle implication, checked on clk with rst_n low as disable
`define HLA_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define HLA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/core/hla_pkg.sv
// package: constants, codes and the sine/cosine table builder for the hough accumulator
package hla_pkg;

    localparam int ANGLE_COUNT_DEF       = 64;
    localparam int MAX_DISTANCE_BINS_DEF = 256;
    localparam int MAX_TAPS_DEF          = 9;
    localparam int COORD_BITS_DEF        = 12;

    // number of weight slots held by the tap weight register
    localparam int WEIGHT_SLOTS = 9;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_FIND  = 2'd3;

    localparam logic [1:0] CFG_BIN_COUNT   = 2'd0;
    localparam logic [1:0] CFG_SCALE       = 2'd1;
    localparam logic [1:0] CFG_TAP_COUNT   = 2'd2;
    localparam logic [1:0] CFG_TAP_WEIGHTS = 2'd3;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // clamp to 0..1.0 and round q30 down to q14
    function automatic logic [15:0] q30_to_q14(input longint v);
        longint t;
        t = v;
        if (t < 0)
        begin
            t = 0;
        end
        if (t > longint'(ONE_Q30))
        begin
            t = longint'(ONE_Q30);
        end
        return 16'((t + 32768) >>> 16);
    endfunction

    // elaboration-time table entry: {cos, sin}, signed q1.14 each
    function automatic logic [31:0] rom_pack(input int unsigned k, input int unsigned Bins);
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] phi;
        logic [63:0] phi2;
        logic [63:0] ts;
        logic [63:0] tc;
        longint      s;
        longint      c;
        logic [15:0] sv;
        logic [15:0] cv;
        logic [15:0] cq;
        logic [15:0] sq;
        quad = 64'(4 * k) / 64'(Bins);
        rem  = 64'(4 * k) % 64'(Bins);
        phi  = PI_HALF_Q30 * rem / 64'(Bins);
        phi2 = (phi * phi) >> 30;
        ts   = phi;
        tc   = ONE_Q30;
        s    = longint'(phi);
        c    = longint'(ONE_Q30);
        for (int n = 1; n <= 7; n++)
        begin
            ts = ((ts * phi2) >> 30) / 64'((2 * n) * (2 * n + 1));
            tc = ((tc * phi2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if ((n % 2) == 1)
            begin
                s = s - longint'(ts);
                c = c - longint'(tc);
            end
            else
            begin
                s = s + longint'(ts);
                c = c + longint'(tc);
            end
        end
        sv = q30_to_q14(s);
        cv = q30_to_q14(c);
        case (quad[1:0])
            2'd0:    begin cq = cv;  sq = sv;  end
            2'd1:    begin cq = -sv; sq = cv;  end
            2'd2:    begin cq = -cv; sq = -sv; end
            default: begin cq = sv;  sq = -cv; end
        endcase
        return {cq, sq};
    endfunction

endpackage

// File: rtl/core/hough_line_accumulator_top.sv
// hough line accumulator: vote store, per-angle distance datapath and command sequencer
//
// hough line voting engine around one single-port-write / single-port-read vote
// store (ANGLE_COUNT x MAX_DISTANCE_BINS counts of 32 bits, registered read). one
// command is worked on at a time; the next transfer is taken once the sequencer is
// back in idle, while a finished result may still sit in the output register.
// steps per command, from transfer in to result ready: add point does one store
// read-modify-write per in-range tap per angle, preceded by table lookup, two
// products, sum, scale and rounding; clear writes one store entry per cycle; read
// does one store read; find maximum reads one store entry per cycle over the bins
// in use. after reset the same clearing pass runs over the whole store before the
// first input transfer.
// configuration writes land in the cycle of cfg_we and must come while idle.
module hough_line_accumulator_top
    import hla_pkg::*;
#(
    parameter int ANGLE_COUNT       = ANGLE_COUNT_DEF,
    parameter int MAX_DISTANCE_BINS = MAX_DISTANCE_BINS_DEF,
    parameter int MAX_TAPS          = MAX_TAPS_DEF,
    parameter int COORD_BITS        = COORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [35:0] cfg_data,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [11:0] x_coord,
    input  logic [11:0] y_coord,
    input  logic [5:0]  angle_index,
    input  logic [7:0]  distance_index,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] bin_value,
    output logic [5:0]  angle_found,
    output logic [7:0]  distance_found
);

`include "hough_line_accumulator_top_defines.svh"

    localparam int DEPTH   = ANGLE_COUNT * MAX_DISTANCE_BINS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ANGLE_W = $clog2(ANGLE_COUNT);
    localparam int DIST_W  = $clog2(MAX_DISTANCE_BINS);
    localparam int NB_W    = $clog2(MAX_DISTANCE_BINS + 1);
    localparam int TAP_W   = $clog2(MAX_TAPS + 1);
    // datapath widths: products, magnitude, scaled product, bin
    localparam int PROD_W  = COORD_BITS + 17;
    localparam int MAG_W   = COORD_BITS + 16;
    localparam int PART_W  = MAG_W + 12;
    localparam int SUM_W   = MAG_W + 25;
    localparam int BMAG_W  = SUM_W - 30;
    localparam int BIN_W   = BMAG_W + 2;
    localparam int FB_W    = BIN_W + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ROM,
        S_MUL,
        S_SUM,
        S_SCALE,
        S_BIN,
        S_TAP,
        S_READ,
        S_RWAIT,
        S_FIND,
        S_FDRAIN,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [8:0]  bin_count_reg;
    logic [23:0] scale_reg;
    logic [3:0]  tap_count_reg;
    logic [35:0] tap_weights_reg;

    // latched command fields
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [5:0]            rd_angle_reg;
    logic [7:0]            rd_dist_reg;

    // sequencing counters
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ANGLE_W-1:0] ang_reg;
    logic [TAP_W-1:0]   tap_reg;
    logic [NB_W-1:0]    fd_reg;

    // per-angle datapath
    logic signed [15:0]       cos_reg;
    logic signed [15:0]       sin_reg;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [PROD_W-1:0] r_reg;
    logic [PART_W-1:0]        plo_reg;
    logic [PART_W-1:0]        phi_reg;
    logic                     neg_reg;
    logic signed [BIN_W-1:0]  bin_reg;

    // pending store write of the read-modify-write
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [3:0]        wr_weight_reg;

    // find-maximum compare stage and result registers
    logic               cmp_valid_reg;
    logic [ANGLE_W-1:0] cmp_angle_reg;
    logic [NB_W-1:0]    cmp_dist_reg;
    logic [31:0]        res_value_reg;
    logic [5:0]         res_angle_reg;
    logic [7:0]         res_dist_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] bin_value_reg;
    logic [5:0]  angle_found_reg;
    logic [7:0]  distance_found_reg;

    // marks a sweep started by the clear command rather than by reset
    logic clr_cmd_reg;

    // vote store
    logic [31:0]       store_mem [DEPTH];
    logic [31:0]       mem_rdata_reg;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;

    // table of cos/sin per angle, built at elaboration
    logic signed [15:0] cos_tab [ANGLE_COUNT];
    logic signed [15:0] sin_tab [ANGLE_COUNT];

    for (genvar k = 0; k < ANGLE_COUNT; k++)
    begin : g_rom
        localparam logic [31:0] ENTRY = rom_pack(k, ANGLE_COUNT);
        assign cos_tab[k] = ENTRY[31:16];
        assign sin_tab[k] = ENTRY[15:0];
    end

    // effective bin and tap counts
    logic [NB_W-1:0]  nb;
    logic [TAP_W-1:0] nt;
    logic [TAP_W-1:0] half_taps;

    assign nb = (11'(bin_count_reg) > 11'(MAX_DISTANCE_BINS)) ?
                NB_W'(MAX_DISTANCE_BINS) : NB_W'(bin_count_reg);
    assign nt = (5'(tap_count_reg) > 5'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : TAP_W'(tap_count_reg);
    assign half_taps = nt >> 1;

    // tap target bin, range check and weight
    logic signed [FB_W-1:0] fb;
    logic                   fb_ok;
    logic [3:0]             tap_w;

    assign fb = FB_W'(bin_reg) + $signed(FB_W'(tap_reg)) - $signed(FB_W'(half_taps));
    assign fb_ok = !fb[FB_W-1] && (fb < $signed(FB_W'(nb)));
    assign tap_w = (5'(tap_reg) < 5'(WEIGHT_SLOTS)) ?
                   4'(tap_weights_reg >> {tap_reg, 2'b00}) : 4'd0;

    // read bin: in range check
    logic rd_ok;
    assign rd_ok = (9'(rd_angle_reg) < 9'(ANGLE_COUNT)) && (11'(rd_dist_reg) < 11'(nb));

    // scaled magnitude and rounded bin
    logic [MAG_W-1:0]  mag_r;
    logic [SUM_W-1:0]  scaled;
    logic [BMAG_W-1:0] bin_mag;

    assign mag_r   = r_reg[PROD_W-1] ? MAG_W'(-r_reg) : MAG_W'(r_reg);
    assign scaled  = (SUM_W'(phi_reg) << 12) + SUM_W'(plo_reg) + (SUM_W'(1) << 29);
    assign bin_mag = BMAG_W'(scaled >> 30);

    // store read port select
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            S_TAP:
            begin
                mem_re    = fb_ok;
                mem_raddr = ADDR_W'(ang_reg) * ADDR_W'(MAX_DISTANCE_BINS)
                            + ADDR_W'(fb[DIST_W-1:0]);
            end
            S_READ:
            begin
                mem_re    = rd_ok;
                mem_raddr = ADDR_W'(rd_angle_reg) * ADDR_W'(MAX_DISTANCE_BINS)
                            + ADDR_W'(rd_dist_reg);
            end
            S_FIND:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(ang_reg) * ADDR_W'(MAX_DISTANCE_BINS) + ADDR_W'(fd_reg);
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // store write port: clearing sweep or saturating vote write-back
    logic [32:0] vote_sum;

    assign vote_sum = {1'b0, mem_rdata_reg} + 33'(wr_weight_reg);

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_pend_reg;
            mem_waddr = wr_addr_reg;
            mem_wdata = vote_sum[32] ? 32'hFFFF_FFFF : vote_sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= store_mem[mem_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg   <= 9'd32;
            scale_reg       <= 24'd65536;
            tap_count_reg   <= 4'd1;
            tap_weights_reg <= 36'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIN_COUNT:   bin_count_reg   <= cfg_data[8:0];
                CFG_SCALE:       scale_reg       <= cfg_data[23:0];
                CFG_TAP_COUNT:   tap_count_reg   <= cfg_data[3:0];
                CFG_TAP_WEIGHTS: tap_weights_reg <= cfg_data;
                default:         tap_weights_reg <= tap_weights_reg;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            x_reg         <= COORD_BITS'(x_coord);
            y_reg         <= COORD_BITS'(y_coord);
            rd_angle_reg  <= angle_index;
            rd_dist_reg   <= distance_index;
            res_value_reg <= '0;
            res_angle_reg <= (command == CMD_READ) ? angle_index : 6'd0;
            res_dist_reg  <= (command == CMD_READ) ? distance_index : 8'd0;
        end
        if (state_reg == S_ROM)
        begin
            cos_reg <= cos_tab[ang_reg];
            sin_reg <= sin_tab[ang_reg];
        end
        if (state_reg == S_MUL)
        begin
            px_reg <= $signed(PROD_W'(x_reg)) * PROD_W'(cos_reg);
            py_reg <= $signed(PROD_W'(y_reg)) * PROD_W'(sin_reg);
        end
        if (state_reg == S_SUM)
        begin
            r_reg <= px_reg + py_reg;
        end
        if (state_reg == S_SCALE)
        begin
            plo_reg <= PART_W'(mag_r) * PART_W'(scale_reg[11:0]);
            phi_reg <= PART_W'(mag_r) * PART_W'(scale_reg[23:12]);
            neg_reg <= r_reg[PROD_W-1];
        end
        if (state_reg == S_BIN)
        begin
            bin_reg <= neg_reg ? -BIN_W'(bin_mag) : BIN_W'(bin_mag);
        end
        wr_addr_reg   <= mem_raddr;
        wr_weight_reg <= tap_w;
        cmp_angle_reg <= ang_reg;
        cmp_dist_reg  <= fd_reg;
        if (state_reg == S_RWAIT)
        begin
            res_value_reg <= rd_ok ? mem_rdata_reg : 32'd0;
        end
        // strictly greater keeps the first maximum
        if (cmp_valid_reg && (mem_rdata_reg > res_value_reg))
        begin
            res_value_reg <= mem_rdata_reg;
            res_angle_reg <= 6'(cmp_angle_reg);
            res_dist_reg  <= 8'(cmp_dist_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cmd_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            clr_cmd_reg <= (command == CMD_CLEAR);
        end
    end

    // sequencer, control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            clr_addr_reg       <= '0;
            ang_reg            <= '0;
            tap_reg            <= '0;
            fd_reg             <= '0;
            wr_pend_reg        <= 1'b0;
            cmp_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            bin_value_reg      <= '0;
            angle_found_reg    <= '0;
            distance_found_reg <= '0;
        end
        else
        begin
            wr_pend_reg   <= (state_reg == S_TAP) && fb_ok;
            cmp_valid_reg <= (state_reg == S_FIND);
            if ((state_reg == S_DONE) && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        clr_addr_reg <= '0;
                        // a clear command reports its result, the reset pass does not
                        state_reg    <= clr_cmd_reg ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ang_reg <= '0;
                        tap_reg <= '0;
                        fd_reg  <= '0;
                        case (command)
                            CMD_ADD:   state_reg <= (nt == '0) ? S_DONE : S_ROM;
                            CMD_CLEAR: state_reg <= S_CLEAR;
                            CMD_READ:  state_reg <= S_READ;
                            default:   state_reg <= (nb == '0) ? S_DONE : S_FIND;
                        endcase
                    end
                end
                S_ROM:   state_reg <= S_MUL;
                S_MUL:   state_reg <= S_SUM;
                S_SUM:   state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_BIN;
                S_BIN:   state_reg <= S_TAP;
                S_TAP:
                begin
                    if (tap_reg == nt - 1'b1)
                    begin
                        tap_reg <= '0;
                        ang_reg <= ang_reg + 1'b1;
                        state_reg <= (ang_reg == ANGLE_W'(ANGLE_COUNT - 1)) ? S_DONE : S_ROM;
                    end
                    else
                    begin
                        tap_reg <= tap_reg + 1'b1;
                    end
                end
                S_READ:  state_reg <= S_RWAIT;
                S_RWAIT: state_reg <= S_DONE;
                S_FIND:
                begin
                    if (fd_reg == nb - 1'b1)
                    begin
                        fd_reg  <= '0;
                        ang_reg <= ang_reg + 1'b1;
                        if (ang_reg == ANGLE_W'(ANGLE_COUNT - 1))
                        begin
                            state_reg <= S_FDRAIN;
                        end
                    end
                    else
                    begin
                        fd_reg <= fd_reg + 1'b1;
                    end
                end
                S_FDRAIN: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        bin_value_reg      <= res_value_reg;
                        angle_found_reg    <= res_angle_reg;
                        distance_found_reg <= res_dist_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign bin_value      = bin_value_reg;
    assign angle_found    = angle_found_reg;
    assign distance_found = distance_found_reg;

    // the vote write-back never hits the entry read in the same cycle
    `HLA_ASSERT_NOW(a_no_rmw_overlap, wr_pend_reg && mem_re, mem_raddr != wr_addr_reg, "read-modify-write overlap on one store entry")
    // no vote write-back during the clearing sweep
    `HLA_ASSERT_NOW(a_no_vote_in_clear, state_reg == S_CLEAR, !wr_pend_reg, "vote write during clear")
    // a vote write-back only follows a tap step
    `HLA_ASSERT_NEXT(a_vote_after_tap, state_reg != S_TAP, !wr_pend_reg, "vote write without tap step")
    // find compare only follows a find read
    `HLA_ASSERT_NEXT(a_cmp_after_find, state_reg != S_FIND, !cmp_valid_reg, "compare without find read")

endmodule

// File: tb/sv/hough_line_accumulator_top_tb.sv
// testbench for the hough line accumulator: directed and random commands against a predictor
module hough_line_accumulator_top_tb
    import hla_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLES     = 64;
    localparam int DIST_MAX   = 256;
    localparam int TAPS_MAX   = 9;
    localparam int CYCLE_CAP  = 6000000;
    localparam int RAND_ITEMS = 900;

    typedef struct packed {
        logic [31:0] count;
        logic [5:0]  ang;
        logic [7:0]  dist_idx;
    } bin_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [35:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [11:0] x_coord;
    logic [11:0] y_coord;
    logic [5:0]  angle_index;
    logic [7:0]  distance_index;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] bin_value;
    logic [5:0]  angle_found;
    logic [7:0]  distance_found;

    hough_line_accumulator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .x_coord        (x_coord),
        .y_coord        (y_coord),
        .angle_index    (angle_index),
        .distance_index (distance_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bin_value      (bin_value),
        .angle_found    (angle_found),
        .distance_found (distance_found)
    );

    // shadow of the vote store and of the registers
    logic [31:0] votes [0:ANGLES*DIST_MAX-1];
    int          cos_q14 [0:ANGLES-1];
    int          sin_q14 [0:ANGLES-1];
    logic [8:0]  bin_count_reg;
    logic [23:0] scale_reg;
    logic [3:0]  tap_count_reg;
    logic [35:0] weights_reg;

    bin_result_t pending_results[$];
    int          fail_count;
    int          result_count;
    int          add_count;
    int          cycle_count;
    bit          idle_on;

    // clock and cycle limit
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("hough_line_accumulator_top: mismatch");
            $finish;
        end
    end

    // receiver stalls at random while idling is on
    always @(posedge clk)
    begin
        out_stall <= idle_on && ($urandom_range(99) < 26);
    end

    // q30 clamp and round to q14
    function automatic int round_q14(input longint v);
        longint t;
        t = v;
        if (t < 0)
        begin
            t = 0;
        end
        if (t > 64'sd1073741824)
        begin
            t = 64'sd1073741824;
        end
        return int'((t + 32768) >>> 16);
    endfunction

    // cosine and sine of angle bin k, full turn, from the taylor series
    task automatic build_trig(input int k);
        bit [63:0] quad, rem, phi, phi2, ts, tc;
        longint    s, c;
        int        sv, cv;
        quad = (4 * k) / ANGLES;
        rem  = (4 * k) % ANGLES;
        phi  = 64'd1686629713 * rem / ANGLES;
        phi2 = (phi * phi) >> 30;
        ts   = phi;
        tc   = 64'd1073741824;
        s    = longint'(phi);
        c    = 64'sd1073741824;
        for (int n = 1; n <= 7; n++)
        begin
            ts = ((ts * phi2) >> 30) / ((2 * n) * (2 * n + 1));
            tc = ((tc * phi2) >> 30) / ((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
            begin
                s = s - longint'(ts);
                c = c - longint'(tc);
            end
            else
            begin
                s = s + longint'(ts);
                c = c + longint'(tc);
            end
        end
        sv = round_q14(s);
        cv = round_q14(c);
        case (quad[1:0])
            2'd0:    begin cos_q14[k] = cv;  sin_q14[k] = sv;  end
            2'd1:    begin cos_q14[k] = -sv; sin_q14[k] = cv;  end
            2'd2:    begin cos_q14[k] = -cv; sin_q14[k] = -sv; end
            default: begin cos_q14[k] = sv;  sin_q14[k] = -cv; end
        endcase
    endtask

    function automatic int bins_used();
        return (bin_count_reg > DIST_MAX) ? DIST_MAX : int'(bin_count_reg);
    endfunction

    // vote one point into every angle row
    function automatic void vote_point(input logic [11:0] px, input logic [11:0] py);
        int        nb, nt, w;
        longint    r, p, mag, center, fb;
        bit [32:0] sum;
        nb = bins_used();
        nt = (tap_count_reg > TAPS_MAX) ? TAPS_MAX : int'(tap_count_reg);
        for (int a = 0; a < ANGLES; a++)
        begin
            r      = longint'(px) * cos_q14[a] + longint'(py) * sin_q14[a];
            p      = r * longint'(scale_reg);
            mag    = (p < 0) ? -p : p;
            mag    = (mag + (64'sd1 << 29)) >>> 30;
            center = (p < 0) ? -mag : mag;
            for (int i = 0; i < nt; i++)
            begin
                fb = center + i - nt / 2;
                w  = (i < 9) ? int'(weights_reg[4*i +: 4]) : 0;
                if (fb >= 0 && fb < nb)
                begin
                    sum = votes[a*DIST_MAX + int'(fb)] + w;
                    votes[a*DIST_MAX + int'(fb)] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
        end
    endfunction

    // expected result of one accepted command
    function automatic bin_result_t predict_command(input logic [1:0] cmd,
        input logic [11:0] px, input logic [11:0] py, input logic [5:0] ai,
        input logic [7:0] di);
        bin_result_t res;
        bit          found;
        res   = '0;
        found = 1'b0;
        case (cmd)
            CMD_ADD:
            begin
                vote_point(px, py);
            end
            CMD_CLEAR:
            begin
                foreach (votes[i])
                begin
                    votes[i] = '0;
                end
            end
            CMD_READ:
            begin
                res.ang      = ai;
                res.dist_idx = di;
                if (di < bins_used())
                begin
                    res.count = votes[int'(ai)*DIST_MAX + int'(di)];
                end
            end
            default:
            begin
                for (int a = 0; a < ANGLES; a++)
                begin
                    for (int d = 0; d < bins_used(); d++)
                    begin
                        if (!found || votes[a*DIST_MAX + d] > res.count)
                        begin
                            found        = 1'b1;
                            res.count    = votes[a*DIST_MAX + d];
                            res.ang      = 6'(a);
                            res.dist_idx = 8'(d);
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    // one command transfer; valid stays up after acceptance until the next
    // call or until drain lowers it
    task automatic send_command(input logic [1:0] cmd, input logic [11:0] px,
        input logic [11:0] py, input logic [5:0] ai, input logic [7:0] di);
        int gap;
        if (idle_on && $urandom_range(99) < 26)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        x_coord        <= px;
        y_coord        <= py;
        angle_index    <= ai;
        distance_index <= di;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_results.push_back(predict_command(cmd, px, py, ai, di));
        if (cmd == CMD_ADD)
        begin
            add_count++;
        end
    endtask

    // lower valid and wait until every result has arrived, plus a margin
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // all four registers in one burst while the block is idle
    task automatic load_config(input logic [8:0] bc, input logic [23:0] sc,
        input logic [3:0] tc, input logic [35:0] tw);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BIN_COUNT;
        cfg_data  <= 36'(bc);
        @(posedge clk);
        cfg_index <= CFG_SCALE;
        cfg_data  <= 36'(sc);
        @(posedge clk);
        cfg_index <= CFG_TAP_COUNT;
        cfg_data  <= 36'(tc);
        @(posedge clk);
        cfg_index <= CFG_TAP_WEIGHTS;
        cfg_data  <= tw;
        @(posedge clk);
        cfg_we        <= 1'b0;
        bin_count_reg = bc;
        scale_reg     = sc;
        tap_count_reg = tc;
        weights_reg   = tw;
    endtask

    // result checker: every transfer out is compared with the oldest expectation
    always @(posedge clk)
    begin
        bin_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count <= result_count + 1;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: value %h angle %0d distance %0d",
                         $realtime, bin_value, angle_found, distance_found);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (bin_value !== exp_res.count)
                begin
                    $display("%0t bin_value expected %h actual %h", $realtime,
                             exp_res.count, bin_value);
                    fail_count++;
                end
                if (angle_found !== exp_res.ang)
                begin
                    $display("%0t angle_found expected %0d actual %0d", $realtime,
                             exp_res.ang, angle_found);
                    fail_count++;
                end
                if (distance_found !== exp_res.dist_idx)
                begin
                    $display("%0t distance_found expected %0d actual %0d", $realtime,
                             exp_res.dist_idx, distance_found);
                    fail_count++;
                end
            end
        end
    end

    // defaults after reset: empty store, then extreme coordinates
    task automatic test_reset_defaults();
        send_command(CMD_READ, 12'd0, 12'd0, 6'd0, 8'd0);
        send_command(CMD_FIND, 12'd0, 12'd0, 6'd0, 8'd0);
        send_command(CMD_ADD, 12'd0, 12'd0, 6'd0, 8'd0);
        send_command(CMD_ADD, 12'd4095, 12'd4095, 6'd0, 8'd0);
        send_command(CMD_READ, 12'd0, 12'd0, 6'd63, 8'd255);
        send_command(CMD_READ, 12'd0, 12'd0, 6'd0, 8'd0);
    endtask

    // full filter and full scale range
    task automatic test_taps_and_scale();
        load_config(9'd256, 24'd2896, 4'd9, 36'hFEDCBA987);
        send_command(CMD_ADD, 12'd4095, 12'd0, 6'd0, 8'd0);
        send_command(CMD_ADD, 12'd0, 12'd4095, 6'd0, 8'd0);
        send_command(CMD_ADD, 12'd2048, 12'd1365, 6'd0, 8'd0);
        send_command(CMD_FIND, 12'd0, 12'd0, 6'd0, 8'd0);
        send_command(CMD_READ, 12'd0, 12'd0, 6'd16, 8'd100);
        // oversize tap count and bin count, largest scale
        load_config(9'd511, 24'hFFFFFF, 4'd15, 36'hFFFFFFFFF);
        send_command(CMD_ADD, 12'd1, 12'd1, 6'd0, 8'd0);
        send_command(CMD_FIND, 12'd0, 12'd0, 6'd0, 8'd0);
    endtask

    // zero bins, zero taps, single bin, clear
    task automatic test_degenerate_config();
        load_config(9'd0, 24'd65536, 4'd0, 36'h123456789);
        send_command(CMD_ADD, 12'd100, 12'd200, 6'd0, 8'd0);
        send_command(CMD_FIND, 12'd0, 12'd0, 6'd0, 8'd0);
        send_command(CMD_READ, 12'd0, 12'd0, 6'd5, 8'd0);
        load_config(9'd1, 24'd0, 4'd3, 36'h000000F51);
        send_command(CMD_ADD, 12'd5, 12'd5, 6'd0, 8'd0);
        send_command(CMD_READ, 12'd0, 12'd0, 6'd0, 8'd0);
        send_command(CMD_CLEAR, 12'd0, 12'd0, 6'd0, 8'd0);
        send_command(CMD_READ, 12'd0, 12'd0, 6'd0, 8'd0);
        send_command(CMD_FIND, 12'd0, 12'd0, 6'd0, 8'd0);
    endtask

    // random phases, each under its own register setting
    task automatic test_random_traffic();
        int          per_phase, pick, bc;
        logic [23:0] sc;
        logic [1:0]  cmd;
        per_phase = RAND_ITEMS / 6;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       bc = 256;
                1:       bc = 1;
                2:       bc = 300;
                default: bc = $urandom_range(2, 160);
            endcase
            // scale that spreads the image diagonal over the bins in use
            sc = 24'((((bc > DIST_MAX) ? DIST_MAX : bc) * 65536) / 5792);
            sc = sc + 24'($urandom_range(0, 200));
            if (ph == 4)
            begin
                sc = 24'($urandom);
            end
            load_config(9'(bc), sc, 4'($urandom_range(0, 15)),
                        {4'($urandom), 32'($urandom)});
            // one phase runs without any idling on either side
            idle_on = (ph != 3);
            for (int n = 0; n < per_phase; n++)
            begin
                pick = $urandom_range(999);
                if (pick < 520)
                begin
                    cmd = CMD_ADD;
                end
                else if (pick < 955)
                begin
                    cmd = CMD_READ;
                end
                else if (pick < 985)
                begin
                    cmd = CMD_FIND;
                end
                else
                begin
                    cmd = CMD_CLEAR;
                end
                send_command(cmd, 12'($urandom), 12'($urandom), 6'($urandom),
                             ($urandom_range(3) == 0) ? 8'($urandom)
                                 : 8'($urandom_range(0, bc > 1 ? bc - 1 : 0)));
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BIN_COUNT;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = CMD_ADD;
        x_coord        = '0;
        y_coord        = '0;
        angle_index    = '0;
        distance_index = '0;
        out_stall      = 1'b0;
        fail_count     = 0;
        result_count   = 0;
        add_count      = 0;
        cycle_count    = 0;
        idle_on        = 1'b1;
        bin_count_reg  = 9'd32;
        scale_reg      = 24'd65536;
        tap_count_reg  = 4'd1;
        weights_reg    = 36'd10;
        foreach (votes[i])
        begin
            votes[i] = '0;
        end
        for (int k = 0; k < ANGLES; k++)
        begin
            build_trig(k);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_taps_and_scale();
        test_degenerate_config();
        test_random_traffic();

        // wait out the last results, then a margin for the result register
        drain();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        $display("checked %0d results, %0d of them point votes, over several register settings",
                 result_count, add_count);
        if (fail_count == 0)
        begin
            $display("hough_line_accumulator_top: match");
        end
        else
        begin
            $display("hough_line_accumulator_top: mismatch");
        end
        $finish;
    end

endmodule
